>>> rtl/tscmd_pkg.sv
package tscmd_pkg;

  // Grid store depth used when the top level is not overridden
  localparam int GRID_CELLS_DEF = 1024;

  // Fixed field widths
  localparam int POS_W   = 32;
  localparam int MASS_W  = 32;
  localparam int CELL_W  = 48;
  localparam int CIDX_W  = 10;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 32;

  // Signed width for grid index math: 32-bit integer part, sign, wrap headroom
  localparam int IXW     = 34;
  // Signed width of the three cloud weights (Q0.16 that may leave [0,1])
  localparam int WW      = 20;
  // Signed width of mass times weight
  localparam int PROD_W  = MASS_W + 1 + WW;

  // Operation codes
  localparam logic [1:0] OP_DEPOSIT = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_WRITE   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_BOUNDARY_MODE     = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_GRID_LEFT_EDGE    = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_INVERSE_CELL_SIZE = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_CELL_COUNT        = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_ACTIVE_START      = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_ACTIVE_END        = 3'd5;

  // Configuration reset values
  localparam logic [31:0] RST_INVERSE_CELL_SIZE = 32'd65536;
  localparam logic [10:0] RST_CELL_COUNT        = 11'd1024;
  localparam logic [10:0] RST_ACTIVE_END        = 11'd1024;

  typedef struct packed {
    logic [1:0]               operation;
    logic signed [POS_W-1:0]  particle_position;
    logic [MASS_W-1:0]        particle_mass;
    logic [CIDX_W-1:0]        cell_index;
    logic signed [CELL_W-1:0] cell_value;
    logic                     batch_end;
  } in_item_t;

  typedef struct packed {
    logic signed [CELL_W-1:0] read_value;
    logic                     dropped;
    logic [CIDX_W-1:0]        center_cell;
    logic                     batch_done;
  } out_item_t;

  typedef struct packed {
    logic                    boundary_mode;
    logic signed [POS_W-1:0] grid_left_edge;
    logic [31:0]             inverse_cell_size;
    logic [10:0]             cell_count;
    logic [9:0]              active_start;
    logic [10:0]             active_end;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_FRAC,
    ST_WGT,
    ST_NBR,
    ST_DEP_RD,
    ST_DEP_WR,
    ST_CELL_RD,
    ST_CELL_WR,
    ST_FIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic diff;
    logic mul;
    logic frac;
    logic wgt;
    logic nbr;
    logic clr_wr;
    logic cell_rd;
    logic cell_wr;
    logic dep_rd;
    logic dep_wr;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] in_op;
    logic       ok;
    logic       k_last;
    logic       clr_last;
  } sts_t;

endpackage

>>> rtl/tsc_mass_deposit_1d.sv
// One-dimensional triangular-shaped-cloud mass deposit into a grid store.
// Input channel in_valid/in_ready/in_data carries one operation per item:
// deposit a particle, read a cell or write a cell. Output channel
// out_valid/out_ready/out_data returns exactly one result per item.
// Configuration is written through cfg_write/cfg_index/cfg_data; the user
// must write it only while idle, as the block itself does not enforce this.
// Steps per item, from acceptance to the next acceptance: a deposit runs a
// 5-stage position and weight sequence, then three read-modify-write passes
// (a read, then a write) on the single-port grid memory, then the result
// load; a dropped deposit skips the passes; a read or a write makes one grid
// access, then the result load; an unused operation has the result load only.
// A result appears on the output the cycle after its load.
// After reset the grid memory is cleared by a sweep over all GRID_CELLS
// cells, one cell per cycle, during which in_ready stays low; configuration
// writes are taken throughout.
// The result sits in an output register: the next item is accepted while it
// waits, and only the load of the following result holds back when the
// receiver stalls.
module tsc_mass_deposit_1d #(
  parameter int GRID_CELLS = tscmd_pkg::GRID_CELLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  tscmd_pkg::in_item_t          in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tscmd_pkg::out_item_t         out_data,
  input  logic                         cfg_write,
  input  logic [tscmd_pkg::CFG_IW-1:0] cfg_index,
  input  logic [tscmd_pkg::CFG_DW-1:0] cfg_data
);
  import tscmd_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  tscmd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tscmd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tscmd_dp #(
    .GRID_CELLS (GRID_CELLS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

>>> rtl/tscmd_cfg.sv
module tscmd_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [tscmd_pkg::CFG_IW-1:0]     cfg_index,
  input  logic [tscmd_pkg::CFG_DW-1:0]     cfg_data,
  output tscmd_pkg::cfg_t                  cfg
);
  import tscmd_pkg::*;

  // Register file; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.boundary_mode     <= 1'b0;
      cfg.grid_left_edge    <= '0;
      cfg.inverse_cell_size <= RST_INVERSE_CELL_SIZE;
      cfg.cell_count        <= RST_CELL_COUNT;
      cfg.active_start      <= '0;
      cfg.active_end        <= RST_ACTIVE_END;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BOUNDARY_MODE:     cfg.boundary_mode     <= cfg_data[0];
        CFG_GRID_LEFT_EDGE:    cfg.grid_left_edge    <= cfg_data;
        CFG_INVERSE_CELL_SIZE: cfg.inverse_cell_size <= cfg_data;
        CFG_CELL_COUNT:        cfg.cell_count        <= cfg_data[10:0];
        CFG_ACTIVE_START:      cfg.active_start      <= cfg_data[9:0];
        CFG_ACTIVE_END:        cfg.active_end        <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/tscmd_ctrl.sv
module tscmd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tscmd_pkg::sts_t   sts,
  output tscmd_pkg::cmd_t   cmd
);
  import tscmd_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  // State and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          case (sts.in_op)
            OP_DEPOSIT: state_next = ST_DIFF;
            OP_READ:    state_next = ST_CELL_RD;
            OP_WRITE:   state_next = ST_CELL_WR;
            default:    state_next = ST_FIN;
          endcase
        end
      end
      ST_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_FRAC;
      end
      ST_FRAC: begin
        cmd.frac   = 1'b1;
        state_next = ST_WGT;
      end
      ST_WGT: begin
        cmd.wgt    = 1'b1;
        state_next = ST_NBR;
      end
      ST_NBR: begin
        cmd.nbr    = 1'b1;
        state_next = sts.ok ? ST_DEP_RD : ST_FIN;
      end
      ST_DEP_RD: begin
        cmd.dep_rd = 1'b1;
        state_next = ST_DEP_WR;
      end
      ST_DEP_WR: begin
        cmd.dep_wr = 1'b1;
        state_next = sts.k_last ? ST_FIN : ST_DEP_RD;
      end
      ST_CELL_RD: begin
        cmd.cell_rd = 1'b1;
        state_next  = ST_FIN;
      end
      ST_CELL_WR: begin
        cmd.cell_wr = 1'b1;
        state_next  = ST_FIN;
      end
      ST_FIN: begin
        // Hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    if (cmd.load_out) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

endmodule

>>> rtl/tscmd_dp.sv
module tscmd_dp #(
  parameter int GRID_CELLS = tscmd_pkg::GRID_CELLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tscmd_pkg::cfg_t      cfg,
  input  tscmd_pkg::in_item_t  in_data,
  input  tscmd_pkg::cmd_t      cmd,
  output tscmd_pkg::sts_t      sts,
  output tscmd_pkg::out_item_t out_data
);
  import tscmd_pkg::*;

  localparam int AW = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
  localparam logic signed [IXW-1:0] GC = IXW'(GRID_CELLS);

  // Captured item
  in_item_t item;

  // Position stages
  logic                    neg;
  logic [31:0]             dmag;
  logic [63:0]             mag;
  logic [33:0]             sq;
  logic signed [18:0]      dx;
  logic signed [IXW-1:0]   i0a;
  logic signed [IXW-1:0]   i0b;
  logic signed [WW-1:0]    wm, w0, wp;
  logic                    ok;
  logic [AW-1:0]           im_addr, ip_addr;
  logic [1:0]              k;
  logic signed [PROD_W-1:0] prod;
  logic [AW-1:0]           clr_cnt;

  // Grid memory
  logic [CELL_W-1:0] mem [0:GRID_CELLS-1];
  logic [CELL_W-1:0] rdata;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_addr;
  logic [CELL_W-1:0] mem_wdata;

  // Combinational helpers
  logic signed [POS_W:0]    diff_c, ndiff_c;
  logic [63:0]              mag_c;
  logic [31:0]              ip_c;
  logic [15:0]              fq_c;
  logic signed [IXW-1:0]    ip_s, i0_c, per_d, st_c, en_c, nb_m, nb_p;
  logic signed [17:0]       fq_s, f_c;
  logic signed [18:0]       s19;
  logic [17:0]              s_c;
  logic signed [WW-1:0]     wm_c, wp_c, dxw;
  logic                     ok_c;
  logic [AW-1:0]            dep_addr;
  logic signed [WW-1:0]     w_sel;
  logic signed [PROD_W-1:0] prod_c;
  logic [CELL_W-1:0]        q_c, sum_c;
  logic                     in_range;

  // Period in cells, clamped to [1, GRID_CELLS]
  always_comb begin
    if (cfg.cell_count == '0) per_d = IXW'(1);
    else if (IXW'(cfg.cell_count) > GC) per_d = GC;
    else per_d = IXW'(cfg.cell_count);
    st_c = IXW'(cfg.active_start);
    en_c = (IXW'(cfg.active_end) > GC) ? GC : IXW'(cfg.active_end);
  end

  assign in_range = (32'(item.cell_index) < 32'(GRID_CELLS));

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load_in) item <= in_data;
  end

  // Offset from the left edge as sign and magnitude
  assign diff_c  = {item.particle_position[POS_W-1], item.particle_position}
                 - {cfg.grid_left_edge[POS_W-1], cfg.grid_left_edge};
  assign ndiff_c = -diff_c;

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      neg  <= diff_c[POS_W];
      dmag <= diff_c[POS_W] ? ndiff_c[31:0] : diff_c[31:0];
    end
  end

  // Scale to grid units, Q32.32
  assign mag_c = dmag * cfg.inverse_cell_size;

  always_ff @(posedge clk) begin
    if (cmd.mul) mag <= mag_c;
  end

  // Integer part, fraction, first wrap and square for the left weight
  always_comb begin
    ip_c = mag[63:32];
    fq_c = mag[31:16];
    ip_s = {2'b00, ip_c};
    i0_c = neg ? -ip_s : ip_s;
    fq_s = {2'b00, fq_c};
    f_c  = neg ? -fq_s : fq_s;
    s19  = 19'sd65536 - {f_c[17], f_c};
    s_c  = s19[17:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.frac) begin
      sq <= s_c * s_c;
      dx <= {f_c[17], f_c} - 19'sd32768;
      if (!cfg.boundary_mode && neg && (ip_c != '0)) i0a <= per_d - ip_s;
      else i0a <= i0_c;
    end
  end

  // Weights and second wrap
  always_comb begin
    dxw  = {dx[18], dx};
    wm_c = {3'b000, sq[33:17]};
    wp_c = dxw + wm_c;
  end

  always_ff @(posedge clk) begin
    if (cmd.wgt) begin
      wm <= wm_c;
      wp <= wp_c;
      w0 <= 20'sd65536 - wp_c - wm_c;
      if (!cfg.boundary_mode && (i0a >= per_d)) i0b <= i0a - per_d;
      else i0b <= i0a;
    end
  end

  // Range check and neighbor cells
  always_comb begin
    if (!cfg.boundary_mode) begin
      ok_c = !i0b[IXW-1] && (i0b < per_d);
      nb_m = (i0b == '0) ? per_d - IXW'(1) : i0b - IXW'(1);
      nb_p = (i0b == per_d - IXW'(1)) ? IXW'(0) : i0b + IXW'(1);
    end else begin
      ok_c = (i0b >= st_c) && (i0b < en_c);
      nb_m = (i0b == st_c) ? st_c : i0b - IXW'(1);
      nb_p = (i0b == en_c - IXW'(1)) ? i0b : i0b + IXW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.nbr) begin
      ok      <= ok_c;
      im_addr <= nb_m[AW-1:0];
      ip_addr <= nb_p[AW-1:0];
    end
  end

  // Cell counter over left, center, right
  always_ff @(posedge clk) begin
    if (cmd.nbr) k <= '0;
    else if (cmd.dep_wr) k <= k + 2'd1;
  end

  always_comb begin
    case (k)
      2'd0: begin
        dep_addr = im_addr;
        w_sel    = wm;
      end
      2'd1: begin
        dep_addr = i0b[AW-1:0];
        w_sel    = w0;
      end
      2'd2: begin
        dep_addr = ip_addr;
        w_sel    = wp;
      end
      default: begin
        dep_addr = i0b[AW-1:0];
        w_sel    = w0;
      end
    endcase
  end

  // Mass times weight, floored to Q16.16
  assign prod_c = $signed({1'b0, item.particle_mass}) * w_sel;

  always_ff @(posedge clk) begin
    if (cmd.dep_rd) prod <= prod_c;
  end

  assign q_c   = {{(CELL_W - (PROD_W - 16)){prod[PROD_W-1]}}, prod[PROD_W-1:16]};
  assign sum_c = rdata + q_c;

  // Clear sweep counter
  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clr_wr) clr_cnt <= clr_cnt + AW'(1);
  end

  // Memory port selection
  always_comb begin
    mem_we = cmd.clr_wr || (cmd.cell_wr && in_range) || cmd.dep_wr;
    mem_re = cmd.cell_rd || cmd.dep_rd;
    if (cmd.clr_wr) begin
      mem_addr  = clr_cnt;
      mem_wdata = '0;
    end else if (cmd.cell_rd || cmd.cell_wr) begin
      mem_addr  = AW'(item.cell_index);
      mem_wdata = item.cell_value;
    end else begin
      mem_addr  = dep_addr;
      mem_wdata = sum_c;
    end
  end

  // Single-port grid store
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_addr];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.read_value  <= (item.operation == OP_READ && in_range) ? rdata : '0;
      out_data.dropped     <= (item.operation == OP_DEPOSIT) && !ok;
      out_data.center_cell <= (item.operation == OP_DEPOSIT && ok) ? i0b[CIDX_W-1:0] : '0;
      out_data.batch_done  <= item.batch_end;
    end
  end

  // Status
  assign sts.in_op    = in_data.operation;
  assign sts.ok       = ok_c;
  assign sts.k_last   = (k == 2'd2);
  assign sts.clr_last = (clr_cnt == AW'(GRID_CELLS - 1));

endmodule
